@@ hdl/vuac_pkg.sv @@
// vuac_pkg: shared types, codes and helpers for the vector unpack address cycler
// used by vuac_lane, vuac_seq and vector_unpack_address_cycler
// no dependencies
package vuac_pkg;

    // unpack format codes (low four bits of the command code)
    localparam logic [3:0] FMT_S32  = 4'h0;
    localparam logic [3:0] FMT_S16  = 4'h1;
    localparam logic [3:0] FMT_S8   = 4'h2;
    localparam logic [3:0] FMT_V2_32 = 4'h4;
    localparam logic [3:0] FMT_V2_16 = 4'h5;
    localparam logic [3:0] FMT_V2_8  = 4'h6;
    localparam logic [3:0] FMT_V4_32 = 4'hc;
    localparam logic [3:0] FMT_V4_16 = 4'hd;
    localparam logic [3:0] FMT_V4_8  = 4'he;

    // item kinds on the input tuser
    localparam logic MODE_CMD = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    // result kinds on the output tuser
    localparam logic STATUS_WRITE  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_CYCLE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_WRITE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_UNIT_SELECT  = 2'd2;

    localparam int ADDR_W  = 10;
    localparam int WORD_W  = 32;
    localparam int REM_W   = 9;
    localparam int NUM_LANES = 4;

    // control from the top level to the address sequencer
    typedef struct packed {
        logic load_cmd;   // accepted command, load run state
        logic reject;     // rejected command, go idle
        logic start_vec;  // vector accepted, restart write count
        logic step;       // emit one quadword write
    } seq_ctrl_t;

    // status from the address sequencer
    typedef struct packed {
        logic              active;     // writes still pending for the command
        logic [ADDR_W-1:0] address;    // masked destination of the current write
        logic              last_write; // current write ends the command
        logic              done;       // current write ends the vector
    } seq_stat_t;

    // true for the formats that this path expands
    function automatic logic fmt_supported(input logic [3:0] f);
        logic ok;
        begin
            case (f) inside
                FMT_S32, FMT_S16, FMT_S8,
                FMT_V2_32, FMT_V2_16, FMT_V2_8,
                FMT_V4_32, FMT_V4_16, FMT_V4_8: ok = 1'b1;
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

@@ hdl/vuac_lane.sv @@
// vuac_lane: expands one 32-bit word of the destination quadword
// from the packed source vector; depends on vuac_pkg
module vuac_lane #(
    parameter int LANE = 0
) (
    input  logic [3:0]  fmt,
    input  logic        zero_ext,
    input  logic [63:0] src_lo,
    input  logic [63:0] src_hi,
    output logic [31:0] word
);
    import vuac_pkg::*;

    localparam int PAIR = LANE % 2;

    logic [127:0] src_all;
    logic [15:0]  h_scalar, h_pair, h_lane;
    logic [7:0]   b_scalar, b_pair, b_lane;

    function automatic logic [31:0] ext16(input logic [15:0] v, input logic z);
        begin
            return z ? {16'h0, v} : {{16{v[15]}}, v};
        end
    endfunction

    function automatic logic [31:0] ext8(input logic [7:0] v, input logic z);
        begin
            return z ? {24'h0, v} : {{24{v[7]}}, v};
        end
    endfunction

    assign src_all  = {src_hi, src_lo};
    assign h_scalar = src_lo[15:0];
    assign h_pair   = src_lo[16*PAIR +: 16];
    assign h_lane   = src_lo[16*LANE +: 16];
    assign b_scalar = src_lo[7:0];
    assign b_pair   = src_lo[8*PAIR +: 8];
    assign b_lane   = src_lo[8*LANE +: 8];

    // component select and extension for this lane
    always_comb
    begin
        case (fmt)
            FMT_S32:   word = src_lo[31:0];
            FMT_S16:   word = ext16(h_scalar, zero_ext);
            FMT_S8:    word = ext8(b_scalar, zero_ext);
            FMT_V2_32: word = src_lo[32*PAIR +: 32];
            FMT_V2_16: word = ext16(h_pair, zero_ext);
            FMT_V2_8:  word = ext8(b_pair, zero_ext);
            FMT_V4_32: word = src_all[32*LANE +: 32];
            FMT_V4_16: word = ext16(h_lane, zero_ext);
            FMT_V4_8:  word = ext8(b_lane, zero_ext);
            default:   word = 32'h0;
        endcase
    end

endmodule

@@ hdl/vuac_seq.sv @@
// vuac_seq: destination address sequencer with skip and fill addressing,
// quadword count and per-vector write cap; depends on vuac_pkg
module vuac_seq #(
    parameter int MAX_WRITES_PER_VECTOR = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vuac_pkg::seq_ctrl_t        ctrl,
    input  logic                       cmd_fill,
    input  logic [vuac_pkg::ADDR_W-1:0] cmd_address,
    input  logic [7:0]                 cmd_count,
    input  logic [7:0]                 cycle_length,
    input  logic [7:0]                 write_length,
    input  logic                       unit_select,
    output vuac_pkg::seq_stat_t        stat
);
    import vuac_pkg::*;

    localparam int CNT_W = $clog2(MAX_WRITES_PER_VECTOR + 1);

    logic              run_fill_reg;
    logic [ADDR_W-1:0] next_address_reg, next_address_next;
    logic [REM_W-1:0]  remaining_reg, remaining_next;
    logic [7:0]        group_position_reg, group_position_next;
    logic [CNT_W-1:0]  write_count_reg, write_count_next;

    logic [REM_W-1:0]  rem_dec;
    logic [ADDR_W-1:0] addr_inc, addr_skip;
    logic [7:0]        gp_inc;
    logic              consumed;
    logic              cap_hit;

    // one write step
    always_comb
    begin
        rem_dec   = remaining_reg - 1'b1;
        addr_inc  = next_address_reg + 1'b1;
        addr_skip = addr_inc + {2'b00, cycle_length} - {2'b00, write_length};
        gp_inc    = group_position_reg + 1'b1;
        write_count_next = write_count_reg + 1'b1;
        cap_hit   = (write_count_next == CNT_W'(MAX_WRITES_PER_VECTOR));
        next_address_next   = addr_inc;
        group_position_next = gp_inc;
        if (run_fill_reg)
        begin
            consumed = (gp_inc <= cycle_length);
            if (!consumed && (gp_inc == write_length))
                group_position_next = 8'h00;
        end
        else
        begin
            consumed = 1'b1;
            if (gp_inc >= write_length)
            begin
                next_address_next   = addr_skip;
                group_position_next = 8'h00;
            end
        end
        remaining_next = rem_dec;
    end

    assign stat.active     = (remaining_reg != '0);
    assign stat.address    = unit_select ? next_address_reg
                                         : {2'b00, next_address_reg[7:0]};
    assign stat.last_write = (rem_dec == '0);
    assign stat.done       = consumed || (rem_dec == '0) || cap_hit;

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_fill_reg       <= 1'b0;
            next_address_reg   <= '0;
            remaining_reg      <= '0;
            group_position_reg <= '0;
            write_count_reg    <= '0;
        end
        else if (ctrl.reject)
        begin
            remaining_reg <= '0;
        end
        else if (ctrl.load_cmd)
        begin
            run_fill_reg       <= cmd_fill;
            next_address_reg   <= cmd_address;
            remaining_reg      <= (cmd_count == 8'h00) ? REM_W'(256) : {1'b0, cmd_count};
            group_position_reg <= '0;
        end
        else if (ctrl.start_vec)
        begin
            write_count_reg <= '0;
        end
        else if (ctrl.step)
        begin
            next_address_reg   <= next_address_next;
            remaining_reg      <= remaining_next;
            group_position_reg <= group_position_next;
            write_count_reg    <= write_count_next;
        end
    end

endmodule

@@ hdl/vector_unpack_address_cycler.sv @@
// Flow: an accepted vector is held in the quadword register and sets busy, so no new input
// is taken while busy; it then gives one quadword write per cycle while out_free holds;
// a vector taken while a command is active gives 1 to MAX_WRITES_PER_VECTOR writes.
// A rejected command gives its result in the cycle after acceptance; other commands, none.
// Reset (rst_n, async low) clears run state and output valid, CL=1, WL=1, unit 0.
// Depends on vuac_pkg, vuac_lane, vuac_seq.
module vector_unpack_address_cycler #(
    parameter int MAX_WRITES_PER_VECTOR = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: format[4:0], unsigned_ext[5], fill[6], start_address[16:7], count[24:17],
    //        src_lo[88:25], src_hi[152:89], zero fill to 160
    input  logic [159:0] s_tdata,
    // tuser: mode
    input  logic         s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: write_address[9:0], word_x[41:10], word_y[73:42], word_z[105:74],
    //        word_w[137:106], zero fill to 144
    output logic [143:0] m_tdata,
    // tuser: status
    output logic         m_tuser,
    output logic         m_tlast
);
    import vuac_pkg::*;

    logic [7:0]  cycle_length_reg;
    logic [7:0]  write_length_reg;
    logic        unit_select_reg;
    logic [3:0]  run_format_reg;
    logic        run_unsigned_reg;
    logic        busy_reg;
    logic [WORD_W-1:0] words_reg [NUM_LANES];
    logic [WORD_W-1:0] lane_word [NUM_LANES];

    logic              out_valid_reg;
    logic              out_status_reg;
    logic              out_last_reg;
    logic [ADDR_W-1:0] out_address_reg;
    logic [WORD_W-1:0] out_word_reg [NUM_LANES];

    logic [4:0]  in_format;
    logic [63:0] in_src_lo, in_src_hi;
    logic        out_free, in_acc, cmd_acc, vec_acc, cmd_bad;
    seq_ctrl_t   ctrl;
    seq_stat_t   stat;

    assign in_format = s_tdata[4:0];
    assign in_src_lo = s_tdata[88:25];
    assign in_src_hi = s_tdata[152:89];

    // handshake and sequencer control
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !busy_reg && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign cmd_acc  = in_acc && (s_tuser == MODE_CMD);
    assign vec_acc  = in_acc && (s_tuser == MODE_VEC);
    assign cmd_bad  = in_format[4] || !fmt_supported(in_format[3:0]);

    assign ctrl.reject    = cmd_acc && cmd_bad;
    assign ctrl.load_cmd  = cmd_acc && !cmd_bad;
    assign ctrl.start_vec = vec_acc && stat.active;
    assign ctrl.step      = busy_reg && out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_length_reg <= 8'd1;
            write_length_reg <= 8'd1;
            unit_select_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CYCLE_LENGTH: cycle_length_reg <= cfg_data;
                CFG_WRITE_LENGTH: write_length_reg <= cfg_data;
                CFG_UNIT_SELECT:  unit_select_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // expansion lanes
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        vuac_lane #(
            .LANE(i)
        ) u_lane (
            .fmt      (run_format_reg),
            .zero_ext (run_unsigned_reg),
            .src_lo   (in_src_lo),
            .src_hi   (in_src_hi),
            .word     (lane_word[i])
        );
    end

    vuac_seq #(
        .MAX_WRITES_PER_VECTOR(MAX_WRITES_PER_VECTOR)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd_fill     (s_tdata[6]),
        .cmd_address  (s_tdata[16:7]),
        .cmd_count    (s_tdata[24:17]),
        .cycle_length (cycle_length_reg),
        .write_length (write_length_reg),
        .unit_select  (unit_select_reg),
        .stat         (stat)
    );

    // run format and busy control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_format_reg   <= '0;
            run_unsigned_reg <= 1'b0;
            busy_reg         <= 1'b0;
        end
        else
        begin
            if (ctrl.load_cmd)
            begin
                run_format_reg   <= in_format[3:0];
                run_unsigned_reg <= s_tdata[5];
            end
            if (ctrl.start_vec)
                busy_reg <= 1'b1;
            else if (ctrl.step && stat.done)
                busy_reg <= 1'b0;
        end
    end

    // merged quadword held for the write steps
    always_ff @(posedge clk)
    begin
        if (ctrl.start_vec)
            words_reg <= lane_word;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.step || ctrl.reject)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            out_status_reg  <= STATUS_WRITE;
            out_address_reg <= stat.address;
            out_word_reg    <= words_reg;
            out_last_reg    <= stat.last_write;
        end
        else if (ctrl.reject)
        begin
            out_status_reg  <= STATUS_REJECT;
            out_address_reg <= '0;
            for (int k = 0; k < NUM_LANES; k++)
                out_word_reg[k] <= '0;
            out_last_reg    <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'h00, out_word_reg[3], out_word_reg[2], out_word_reg[1],
                       out_word_reg[0], out_address_reg};

endmodule
